@@ design/contiguous_block_allocator_unit_defines.svh @@
// assertion macros for the contiguous block allocator checker
// no dependencies; included by the checker file only
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// property checked at each rising edge, off while rst is high
`define CBAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at each rising edge, reset included
`define CBAU_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/cbau_pkg.sv @@
// shared types, widths and codes for the contiguous block allocator
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package cbau_pkg;

   localparam int DEF_NUM_BLOCKS      = 256;
   localparam int DEF_BLOCK_BYTE_BITS = 16;

   localparam int FILE_SIZE_W   = 24;
   localparam int FIRST_BLOCK_W = 8;
   localparam int RUN_LEN_W     = 9;
   localparam int PLACED_W      = 8;
   localparam int NEXT_FIT_W    = 9;
   localparam int BLOCK_SIZE_W  = 16;
   localparam int BLK_USE_W     = 9;
   localparam int TAKEN_W       = 9;

   localparam int REQ_TDATA_W   = 48;
   localparam int RSP_FIELDS_W  = 1 + PLACED_W + NEXT_FIT_W;
   localparam int RSP_TDATA_W   = 24;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_FIELDS_W;

   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 16'd512;
   localparam logic [BLK_USE_W-1:0]    BLK_USE_RESET    = 9'd256;

   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic REG_BLOCK_SIZE    = 1'b0;
   localparam logic REG_BLOCKS_IN_USE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_PRIME,
      ST_SCAN,
      ST_FILL,
      ST_WRAP_PRIME,
      ST_WRAP,
      ST_REMOVE,
      ST_RESP
   } state_type;

endpackage

@@ design/cbau_table.sv @@
// block table memory: used and fragment byte counts per block
// depends on cbau_pkg; one shared address, write or registered read
`timescale 1ns / 1ps

module cbau_table
   import cbau_pkg::*;
#(
   parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS,
   parameter int BLOCK_BYTE_BITS = DEF_BLOCK_BYTE_BITS
) (
   input  logic                               clock,
   input  logic                               we,
   input  logic [$clog2(NUM_BLOCKS)-1:0]      addr,
   input  logic [BLOCK_BYTE_BITS-1:0]         wused,
   input  logic [BLOCK_BYTE_BITS-1:0]         wfrag,
   output logic [BLOCK_BYTE_BITS-1:0]         rused
);

   logic [2*BLOCK_BYTE_BITS-1:0] mem [NUM_BLOCKS];
   logic [BLOCK_BYTE_BITS-1:0]   rused_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= {wfrag, wused};
      end
      rused_ff <= mem[addr][BLOCK_BYTE_BITS-1:0];
   end

   assign rused = rused_ff;

endmodule

@@ design/cbau_fill.sv @@
// fill step: splits the remaining file bytes into one block's worth
// depends on cbau_pkg; used by the sequencer once per written block
`timescale 1ns / 1ps

module cbau_fill
   import cbau_pkg::*;
#(
   parameter int BLOCK_BYTE_BITS = DEF_BLOCK_BYTE_BITS
) (
   input  logic [FILE_SIZE_W-1:0]     rem,
   input  logic [BLOCK_SIZE_W-1:0]    bs,
   output logic [FILE_SIZE_W-1:0]     rem_next,
   output logic [BLOCK_BYTE_BITS-1:0] used_w,
   output logic [BLOCK_BYTE_BITS-1:0] frag_w
);

   logic [FILE_SIZE_W:0]   bs_minus_rem;
   logic [FILE_SIZE_W-1:0] rem_minus_bs;
   logic                   more;

   always_comb begin
      bs_minus_rem = {1'b0, FILE_SIZE_W'(bs)} - {1'b0, rem};
      rem_minus_bs = rem - FILE_SIZE_W'(bs);
      more         = bs_minus_rem[FILE_SIZE_W];
      if (more) begin
         rem_next = rem_minus_bs;
         used_w   = BLOCK_BYTE_BITS'(bs);
         frag_w   = '0;
      end else begin
         rem_next = '0;
         used_w   = BLOCK_BYTE_BITS'(rem);
         frag_w   = BLOCK_BYTE_BITS'(bs_minus_rem[FILE_SIZE_W-1:0]);
      end
   end

endmodule

@@ design/cbau_ctrl.sv @@
// sequencer: clear pass, run scan, fill, pointer wrap, remove, result register
// depends on cbau_pkg and cbau_fill; drives the cbau_table port
`timescale 1ns / 1ps

module cbau_ctrl
   import cbau_pkg::*;
#(
   parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS,
   parameter int BLOCK_BYTE_BITS = DEF_BLOCK_BYTE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [FILE_SIZE_W-1:0]        req_size,
   input  logic [FIRST_BLOCK_W-1:0]      req_first,
   input  logic [RUN_LEN_W-1:0]          req_len,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [PLACED_W-1:0]           rsp_placed,
   output logic [NEXT_FIT_W-1:0]         rsp_next,
   input  logic [BLOCK_SIZE_W-1:0]       block_size,
   input  logic [BLK_USE_W-1:0]          blocks_in_use,
   output logic                          tbl_we,
   output logic [$clog2(NUM_BLOCKS)-1:0] tbl_addr,
   output logic [BLOCK_BYTE_BITS-1:0]    tbl_wused,
   output logic [BLOCK_BYTE_BITS-1:0]    tbl_wfrag,
   input  logic [BLOCK_BYTE_BITS-1:0]    tbl_rused
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int PTR_W  = (CNT_W > FIRST_BLOCK_W) ? CNT_W : FIRST_BLOCK_W;
   localparam int WIDE_W = ((PTR_W > RUN_LEN_W) ? PTR_W : RUN_LEN_W) + 2;

   state_type              state_ff, state_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [PTR_W-1:0]       k_ff, k_in;
   logic [PTR_W-1:0]       j_ff, j_in;
   logic [RUN_LEN_W-1:0]   run_ff, run_in;
   logic [RUN_LEN_W-1:0]   w_ff, w_in;
   logic [RUN_LEN_W-1:0]   len_ff, len_in;
   logic [FILE_SIZE_W-1:0] rem_ff, rem_in;
   logic [FIRST_BLOCK_W-1:0] first_ff, first_in;
   logic                   pass_ff, pass_in;
   logic [TAKEN_W-1:0]     taken_ff, taken_in;
   logic                   res_acc_ff, res_acc_in;
   logic [PLACED_W-1:0]    res_placed_ff, res_placed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   acc_ff, acc_in;
   logic [PLACED_W-1:0]    placed_ff, placed_in;
   logic [NEXT_FIT_W-1:0]  next_ff, next_in;

   logic [WIDE_W-1:0]      n_wide;
   logic [BLOCK_SIZE_W-1:0] bs_eff;
   logic [FILE_SIZE_W-1:0] fill_rem;
   logic [BLOCK_BYTE_BITS-1:0] fill_used;
   logic [BLOCK_BYTE_BITS-1:0] fill_frag;
   logic [WIDE_W-1:0]      kw_sum;
   logic [WIDE_W-1:0]      rm_idx;
   logic [TAKEN_W:0]       taken_sum;
   logic [RUN_LEN_W-1:0]   run_inc;
   logic                   scan_fail;
   logic                   busy;

   cbau_fill #(
      .BLOCK_BYTE_BITS(BLOCK_BYTE_BITS)
   ) u_fill (
      .rem      (rem_ff),
      .bs       (bs_eff),
      .rem_next (fill_rem),
      .used_w   (fill_used),
      .frag_w   (fill_frag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         j_ff         <= '0;
         ptr_ff       <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         ptr_ff       <= ptr_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      run_ff        <= run_in;
      w_ff          <= w_in;
      len_ff        <= len_in;
      rem_ff        <= rem_in;
      first_ff      <= first_in;
      pass_ff       <= pass_in;
      res_acc_ff    <= res_acc_in;
      res_placed_ff <= res_placed_in;
      acc_ff        <= acc_in;
      placed_ff     <= placed_in;
      next_ff       <= next_in;
   end

   always_comb begin
      n_wide = (WIDE_W'(blocks_in_use) < WIDE_W'(NUM_BLOCKS)) ?
               WIDE_W'(blocks_in_use) : WIDE_W'(NUM_BLOCKS);
      bs_eff    = (block_size == '0) ? BLOCK_SIZE_W'(1) : block_size;
      kw_sum    = WIDE_W'(k_ff) + WIDE_W'(w_ff);
      rm_idx    = WIDE_W'(first_ff) + WIDE_W'(w_ff);
      taken_sum = {1'b0, taken_ff} + (TAKEN_W+1)'(len_ff);
      run_inc   = run_ff + RUN_LEN_W'(1);
      busy      = (tbl_rused != '0);

      state_in      = state_ff;
      ptr_in        = ptr_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      run_in        = run_ff;
      w_in          = w_ff;
      len_in        = len_ff;
      rem_in        = rem_ff;
      first_in      = first_ff;
      pass_in       = pass_ff;
      taken_in      = taken_ff;
      res_acc_in    = res_acc_ff;
      res_placed_in = res_placed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      acc_in        = acc_ff;
      placed_in     = placed_ff;
      next_in       = next_ff;
      req_ready     = 1'b0;
      tbl_we        = 1'b0;
      tbl_addr      = IDX_W'(j_ff);
      tbl_wused     = '0;
      tbl_wfrag     = '0;
      scan_fail     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_we = 1'b1;
            j_in   = j_ff + PTR_W'(1);
            if (WIDE_W'(j_ff) == WIDE_W'(NUM_BLOCKS - 1)) begin
               j_in     = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               len_in   = req_len;
               rem_in   = req_size;
               first_in = req_first;
               w_in     = '0;
               run_in   = '0;
               pass_in  = 1'b0;
               if (req_kind == REQ_REMOVE) begin
                  state_in = ST_REMOVE;
               end else if (req_len == '0) begin
                  k_in     = (WIDE_W'(ptr_ff) <= n_wide) ? ptr_ff : '0;
                  state_in = ST_FILL;
               end else begin
                  k_in     = ptr_ff;
                  j_in     = ptr_ff;
                  state_in = ST_SCAN_PRIME;
               end
            end
         end
         ST_SCAN_PRIME: begin
            if (WIDE_W'(j_ff) >= n_wide) begin
               scan_fail = 1'b1;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tbl_addr = IDX_W'(j_ff + PTR_W'(1));
            if (WIDE_W'(j_ff) >= n_wide) begin
               scan_fail = 1'b1;
            end else begin
               j_in = j_ff + PTR_W'(1);
               if (busy) begin
                  k_in   = j_ff + PTR_W'(1);
                  run_in = '0;
               end else begin
                  run_in = run_inc;
                  if (run_inc == len_ff) begin
                     if (pass_ff &&
                         (WIDE_W'(k_ff) + WIDE_W'(len_ff) > WIDE_W'(ptr_ff))) begin
                        res_acc_in    = 1'b0;
                        res_placed_in = '0;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_FILL;
                     end
                  end
               end
            end
         end
         ST_FILL: begin
            tbl_addr = IDX_W'(kw_sum);
            if ((w_ff < len_ff) && (rem_ff != '0)) begin
               tbl_we    = 1'b1;
               tbl_wused = fill_used;
               tbl_wfrag = fill_frag;
               rem_in    = fill_rem;
               w_in      = w_ff + RUN_LEN_W'(1);
            end else begin
               ptr_in        = PTR_W'(kw_sum);
               res_acc_in    = 1'b1;
               res_placed_in = PLACED_W'(k_ff);
               taken_in      = taken_sum[TAKEN_W] ? '1 : taken_sum[TAKEN_W-1:0];
               j_in          = '0;
               state_in      = (kw_sum >= n_wide) ? ST_WRAP_PRIME : ST_RESP;
            end
         end
         ST_WRAP_PRIME: begin
            state_in = (WIDE_W'(j_ff) >= n_wide) ? ST_RESP : ST_WRAP;
         end
         ST_WRAP: begin
            tbl_addr = IDX_W'(j_ff + PTR_W'(1));
            if (WIDE_W'(j_ff) >= n_wide) begin
               state_in = ST_RESP;
            end else if (!busy) begin
               ptr_in   = j_ff;
               state_in = ST_RESP;
            end else begin
               j_in = j_ff + PTR_W'(1);
            end
         end
         ST_REMOVE: begin
            tbl_addr = IDX_W'(rm_idx);
            if (w_ff < len_ff) begin
               tbl_we = (rm_idx < WIDE_W'(NUM_BLOCKS));
               w_in   = w_ff + RUN_LEN_W'(1);
            end else begin
               ptr_in        = PTR_W'(first_ff);
               res_acc_in    = 1'b1;
               res_placed_in = '0;
               taken_in      = (taken_ff > len_ff) ? taken_ff - len_ff : '0;
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               acc_in       = res_acc_ff;
               placed_in    = res_placed_ff;
               next_in      = NEXT_FIT_W'(ptr_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_fail) begin
         if (!pass_ff) begin
            pass_in  = 1'b1;
            j_in     = '0;
            k_in     = '0;
            run_in   = '0;
            state_in = ST_SCAN_PRIME;
         end else begin
            res_acc_in    = 1'b0;
            res_placed_in = '0;
            state_in      = ST_RESP;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_placed   = placed_ff;
   assign rsp_next     = next_ff;

endmodule

@@ design/contiguous_block_allocator_unit.sv @@
// add: run scan, then one table write per block written, then pointer wrap search
// remove: one table write per block of the run inside the table; one table access per cycle
// one request in flight at a time; the result register frees the next accept
// reset (synchronous) starts a clearing pass over every table entry, no request taken
// top level: stream channels, csr port, sequencer and block table
// depends on cbau_pkg, cbau_ctrl, cbau_table
`timescale 1ns / 1ps

module contiguous_block_allocator_unit
   import cbau_pkg::*;
#(
   parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS,
   parameter int BLOCK_BYTE_BITS = DEF_BLOCK_BYTE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // file_size [23:0], first_block [31:24], run_length [40:32]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type [0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // accepted [0], placed_start [8:1], next_fit [17:9]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);

   logic [BLOCK_SIZE_W-1:0]    block_size_ff, block_size_in;
   logic [BLK_USE_W-1:0]       blocks_in_use_ff, blocks_in_use_in;
   logic                       csr_wr;
   logic                       rsp_accepted;
   logic [PLACED_W-1:0]        rsp_placed;
   logic [NEXT_FIT_W-1:0]      rsp_next;
   logic                       tbl_we;
   logic [IDX_W-1:0]           tbl_addr;
   logic [BLOCK_BYTE_BITS-1:0] tbl_wused;
   logic [BLOCK_BYTE_BITS-1:0] tbl_wfrag;
   logic [BLOCK_BYTE_BITS-1:0] tbl_rused;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff    <= BLOCK_SIZE_RESET;
         blocks_in_use_ff <= BLK_USE_RESET;
      end else begin
         block_size_ff    <= block_size_in;
         blocks_in_use_ff <= blocks_in_use_in;
      end
   end

   always_comb begin
      block_size_in    = block_size_ff;
      blocks_in_use_in = blocks_in_use_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_BLOCK_SIZE:    block_size_in    = csr_pwdata[BLOCK_SIZE_W-1:0];
            REG_BLOCKS_IN_USE: blocks_in_use_in = csr_pwdata[BLK_USE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_BLOCK_SIZE:    csr_prdata = CSR_DATA_W'(block_size_ff);
         REG_BLOCKS_IN_USE: csr_prdata = CSR_DATA_W'(blocks_in_use_ff);
         default:           csr_prdata = '0;
      endcase
   end

   cbau_ctrl #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .BLOCK_BYTE_BITS (BLOCK_BYTE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_kind      (req_tuser),
      .req_size      (req_tdata[FILE_SIZE_W-1:0]),
      .req_first     (req_tdata[FILE_SIZE_W +: FIRST_BLOCK_W]),
      .req_len       (req_tdata[FILE_SIZE_W+FIRST_BLOCK_W +: RUN_LEN_W]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_accepted  (rsp_accepted),
      .rsp_placed    (rsp_placed),
      .rsp_next      (rsp_next),
      .block_size    (block_size_ff),
      .blocks_in_use (blocks_in_use_ff),
      .tbl_we        (tbl_we),
      .tbl_addr      (tbl_addr),
      .tbl_wused     (tbl_wused),
      .tbl_wfrag     (tbl_wfrag),
      .tbl_rused     (tbl_rused)
   );

   cbau_table #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .BLOCK_BYTE_BITS (BLOCK_BYTE_BITS)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .addr  (tbl_addr),
      .wused (tbl_wused),
      .wfrag (tbl_wfrag),
      .rused (tbl_rused)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_next, rsp_placed, rsp_accepted};

endmodule

@@ design/cbau_checker.sv @@
// port-level checks for the contiguous block allocator, bound to the top level
// depends on contiguous_block_allocator_unit_defines.svh
`timescale 1ns / 1ps
`include "contiguous_block_allocator_unit_defines.svh"

module cbau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `CBAU_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `CBAU_ASSERT(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   `CBAU_ASSERT(a_refused_placed, clock, reset, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'd0, "refused add with nonzero start")
   `CBAU_ASSERT_NR(a_reset_clear, clock, reset |=> !rsp_tvalid && !req_tready, "channels active during table clear")

endmodule

bind contiguous_block_allocator_unit cbau_checker u_cbau_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for contiguous_block_allocator_unit: streams add and remove
// requests, predicts every result from a block table of its own and checks each field
// depends on cbau_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb_top;
   import cbau_pkg::*;

   localparam int NUM_BLOCKS  = DEF_NUM_BLOCKS;
   localparam int BYTE_BITS   = DEF_BLOCK_BYTE_BITS;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 1100;
   localparam int NUM_PHASES  = 8;
   localparam int REQ_PAD_W   = REQ_TDATA_W - FILE_SIZE_W - FIRST_BLOCK_W - RUN_LEN_W;

   typedef struct {
      logic                     kind;
      logic [FILE_SIZE_W-1:0]   file_size;
      logic [FIRST_BLOCK_W-1:0] first_block;
      logic [RUN_LEN_W-1:0]     run_length;
   } alloc_req_t;

   typedef struct {
      logic                  accepted;
      logic [PLACED_W-1:0]   placed;
      logic [NEXT_FIT_W-1:0] next_fit;
   } alloc_reply_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // file_size [23:0], first_block [31:24], run_length [40:32]
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // req_type [0]
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // accepted [0], placed_start [8:1], next_fit [17:9]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // block table mirror and register copies
   logic [BYTE_BITS-1:0]    blk_used [NUM_BLOCKS];
   logic [BYTE_BITS-1:0]    blk_frag [NUM_BLOCKS];
   int unsigned             fit_ptr = 0;
   logic [BLOCK_SIZE_W-1:0] cfg_block_size = BLOCK_SIZE_RESET;
   logic [BLK_USE_W-1:0]    cfg_blocks = BLK_USE_RESET;

   alloc_req_t   pending_reqs [$];
   alloc_reply_t awaited_replies [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          req_sent = 1'b0;
   bit          drain_hold = 1'b0;
   int unsigned err_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned placed_count = 0;
   int unsigned refused_count = 0;
   int unsigned remove_count = 0;

   int unsigned ph_bsize  [NUM_PHASES] = '{512, 64, 0, 65535, 1, 300, 4096, 17};
   int unsigned ph_blocks [NUM_PHASES] = '{256, 16, 8, 32, 1, 400, 64, 24};
   int unsigned ph_send   [NUM_PHASES] = '{0, 82, 0, 8, 0, 8, 82, 0};
   int unsigned ph_recv   [NUM_PHASES] = '{0, 0, 82, 8, 0, 8, 0, 82};
   int unsigned ph_items  [NUM_PHASES] = '{100, 150, 150, 150, 100, 80, 150, 150};

   contiguous_block_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         blk_used[b] = '0;
         blk_frag[b] = '0;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         err_count++;
      end
   endfunction

   // lowest start at or after from whose next len blocks are free, never past block n-1
   function automatic int unsigned free_run_from(input int unsigned from,
                                                 input int unsigned len,
                                                 input int unsigned n);
      int unsigned k;
      int unsigned i;
      k = from;
      i = from;
      while (i < k + len && i < n) begin
         if (blk_used[i] != 0) k = i + 1;
         i++;
      end
      return k;
   endfunction

   function automatic alloc_reply_t predict_reply(input alloc_req_t r);
      alloc_reply_t y;
      int unsigned  n;
      int unsigned  p;
      int unsigned  k;
      int unsigned  bs;
      int unsigned  rem;
      int unsigned  w;
      bit           ok;
      bit           found;
      n = (cfg_blocks < NUM_BLOCKS) ? cfg_blocks : NUM_BLOCKS;
      y.accepted = 1'b1;
      y.placed = '0;
      if (r.kind == REQ_REMOVE) begin
         for (w = 0; w < r.run_length; w++) begin
            if (r.first_block + w < NUM_BLOCKS) begin
               blk_used[r.first_block + w] = '0;
               blk_frag[r.first_block + w] = '0;
            end
         end
         fit_ptr = r.first_block;
         remove_count++;
      end else begin
         p = fit_ptr;
         k = free_run_from(p, r.run_length, n);
         ok = (k + r.run_length <= n);
         if (!ok) begin
            // wrapped search may not run past the pointer
            k = free_run_from(0, r.run_length, n);
            ok = (k + r.run_length <= n) && (k + r.run_length <= p);
         end
         if (!ok) begin
            y.accepted = 1'b0;
            refused_count++;
         end else begin
            bs = (cfg_block_size == 0) ? 1 : cfg_block_size;
            rem = r.file_size;
            w = 0;
            while (w < r.run_length && rem > 0) begin
               if (rem > bs) begin
                  blk_used[k + w] = bs[BYTE_BITS-1:0];
                  blk_frag[k + w] = '0;
                  rem -= bs;
               end else begin
                  blk_used[k + w] = rem[BYTE_BITS-1:0];
                  blk_frag[k + w] = BYTE_BITS'(bs - rem);
                  rem = 0;
               end
               w++;
            end
            y.placed = k[PLACED_W-1:0];
            fit_ptr = k + w;
            if (fit_ptr >= n) begin
               found = 1'b0;
               for (int i = 0; i < n; i++) begin
                  if (!found && blk_used[i] == 0) begin
                     fit_ptr = i;
                     found = 1'b1;
                  end
               end
            end
            placed_count++;
         end
      end
      y.next_fit = fit_ptr[NEXT_FIT_W-1:0];
      return y;
   endfunction

   // checks results, predicts each accepted request and watches for a hang
   always @(posedge clock) begin
      alloc_req_t   acc;
      alloc_reply_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_replies.size() == 0) begin
               $error("result transfer with no request outstanding");
               err_count++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("accepted", want.accepted, rsp_tdata[0]);
               check_field("placed_start", want.placed, rsp_tdata[PLACED_W:1]);
               check_field("next_fit", want.next_fit,
                           rsp_tdata[PLACED_W+1 +: NEXT_FIT_W]);
            end
         end
         if (req_tvalid && req_tready) begin
            acc.kind = req_tuser;
            acc.file_size = req_tdata[FILE_SIZE_W-1:0];
            acc.first_block = req_tdata[FILE_SIZE_W +: FIRST_BLOCK_W];
            acc.run_length = req_tdata[FILE_SIZE_W+FIRST_BLOCK_W +: RUN_LEN_W];
            awaited_replies.push_back(predict_reply(acc));
            req_sent = 1'b1;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      alloc_req_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_sent) begin
         req_sent = 1'b0;
         if (drain_hold && awaited_replies.size() == 0) drain_hold = 1'b0;
         if (pending_reqs.size() != 0 && !drain_hold &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.kind;
            req_tdata <= {{REQ_PAD_W{1'b0}}, nxt.run_length, nxt.first_block, nxt.file_size};
            drain_hold = ($urandom_range(0, 99) == 0);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic push_req(input logic kind, input logic [FILE_SIZE_W-1:0] fsize,
                           input logic [FIRST_BLOCK_W-1:0] first,
                           input logic [RUN_LEN_W-1:0] len);
      alloc_req_t r;
      r.kind = kind;
      r.file_size = fsize;
      r.first_block = first;
      r.run_length = len;
      pending_reqs.push_back(r);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_register(input logic idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, {idx, 2'b00}, value, rd);
      if (idx == REG_BLOCK_SIZE) begin
         cfg_block_size = value[BLOCK_SIZE_W-1:0];
         csr_access(1'b0, {idx, 2'b00}, '0, rd);
         check_field("block_size", cfg_block_size, rd);
      end else begin
         cfg_blocks = value[BLK_USE_W-1:0];
         csr_access(1'b0, {idx, 2'b00}, '0, rd);
         check_field("blocks_in_use", cfg_blocks, rd);
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || awaited_replies.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rd;
      int unsigned n_eff;
      int unsigned bs_eff;
      int unsigned span;
      int unsigned sel;
      int unsigned len;
      int unsigned top;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, {REG_BLOCK_SIZE, 2'b00}, '0, rd);
      check_field("block_size", BLOCK_SIZE_RESET, rd);
      csr_access(1'b0, {REG_BLOCKS_IN_USE, 2'b00}, '0, rd);
      check_field("blocks_in_use", BLK_USE_RESET, rd);

      // directed: reset settings, 512-byte blocks over the whole table
      push_req(REQ_ADD, 0, 0, 0);
      push_req(REQ_ADD, 1000, 0, 2);
      push_req(REQ_ADD, 5000, 0, 3);              // file larger than its run
      push_req(REQ_ADD, 100, 0, 4);               // run longer than the file
      push_req(REQ_ADD, 10, 0, 256);              // no room anywhere
      push_req(REQ_ADD, 24'hFFFFFF, 8'hFF, 250);  // fills table, pointer left at end
      push_req(REQ_ADD, 1, 0, 1);
      push_req(REQ_REMOVE, 0, 255, 511);          // runs off the end of the table
      push_req(REQ_REMOVE, 0, 10, 3);
      push_req(REQ_ADD, 512, 0, 1);               // exactly one block
      push_req(REQ_ADD, 1, 0, 2);
      push_req(REQ_ADD, 7, 0, 2);
      push_req(REQ_REMOVE, 0, 0, 4);
      push_req(REQ_REMOVE, 0, 254, 1);
      push_req(REQ_REMOVE, 0, 2, 1);              // block already free
      push_req(REQ_ADD, 2000, 0, 3);              // wrapped run ends past pointer
      push_req(REQ_REMOVE, 0, 3, 1);
      push_req(REQ_ADD, 2000, 0, 3);              // wrapped run ends at pointer
      push_req(REQ_ADD, 0, 0, 1);                 // zero bytes
      push_req(REQ_REMOVE, 24'hAAAAAA, 8'hAA, 0);
      push_req(REQ_REMOVE, 24'h555555, 8'h55, 0);
      push_req(REQ_REMOVE, 0, 250, 6);
      push_req(REQ_ADD, 3072, 0, 6);              // pointer hits end, moves to free block

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         set_register(REG_BLOCK_SIZE, ph_bsize[ph]);
         set_register(REG_BLOCKS_IN_USE, ph_blocks[ph]);
         send_idle_pct = ph_send[ph];
         recv_stall_pct = ph_recv[ph];
         n_eff = (ph_blocks[ph] < NUM_BLOCKS) ? ph_blocks[ph] : NUM_BLOCKS;
         bs_eff = (ph_bsize[ph] == 0) ? 1 : ph_bsize[ph];
         span = (n_eff < 6) ? n_eff : 6;
         for (int i = 0; i < ph_items[ph]; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
               push_req($urandom_range(0, 1), $urandom_range(0, 24'hFFFFFF),
                        $urandom_range(0, 255), $urandom_range(0, 511));
            end else if (sel < 45) begin
               push_req(REQ_REMOVE, $urandom_range(0, 24'hFFFFFF),
                        $urandom_range(0, n_eff - 1), $urandom_range(1, span));
            end else begin
               len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n_eff)
                                                  : $urandom_range(0, span);
               top = len * bs_eff + bs_eff;
               if (top > 24'hFFFFFF) top = 24'hFFFFFF;
               push_req(REQ_ADD, $urandom_range(0, top), $urandom_range(0, 255), len);
            end
         end
      end

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d placed adds, %0d refused adds and %0d removes", placed_count,
               refused_count, remove_count);
      $display("over %0d block size and block count settings plus reset values",
               NUM_PHASES);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
